// ----- rtl/core/rgg_pkg.sv -----
// Shared types, widths and constants for the rhythmic gate gain block.
`timescale 1ns / 1ps
`default_nettype none

package rgg_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int CHANNELS        = 2;
	localparam int COUNT_W         = 24;
	localparam int PERIOD_W        = 20;
	localparam int MIX_W           = 16;
	localparam int GAIN_W          = 16;
	localparam int DECLICK_DEFAULT = 12;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int REG_IDX_W       = 2;
	localparam int TDATA_IN_W      = CHANNELS * SAMPLE_W + COUNT_W;
	localparam int TDATA_OUT_W     = CHANNELS * SAMPLE_W;

	localparam logic [GAIN_W-1:0] UNITY_Q15 = 16'h8000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PERIOD = 2'd0,
		REG_ON     = 2'd1,
		REG_MIX    = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] on;
		logic [MIX_W-1:0]    mix;
	} cfg_t;

	// One classified frame: samples, pass-through flag and Q1.15 gate value
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       pass;
		logic [GAIN_W-1:0]          gain;
	} gate_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/rgg_front.sv -----
// Front end: accepts frames, pipelined phase remainder, gate value lookup.
`timescale 1ns / 1ps
`default_nettype none

module rgg_front #(
	parameter int DECLICK_FRAMES = rgg_pkg::DECLICK_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rgg_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [rgg_pkg::SAMPLE_W-1:0] left_in,
	input  logic signed [rgg_pkg::SAMPLE_W-1:0] right_in,
	input  logic [rgg_pkg::COUNT_W-1:0]        count_in,
	input  logic                               bypass_in,
	output rgg_pkg::gate_item_t                item,
	output logic                               item_valid,
	input  logic                               item_ready
);
	import rgg_pkg::*;

	localparam int KW   = (DECLICK_FRAMES > 1) ? $clog2(DECLICK_FRAMES) : 1;
	localparam int LAST = COUNT_W - 1;

	// restoring remainder, one count bit per stage
	logic [COUNT_W-1:0]         vld_s;
	logic [COUNT_W-1:0]         pass_s;
	logic [PERIOD_W-1:0]        rem_s   [COUNT_W];
	logic [COUNT_W-1:0]         cnt_s   [COUNT_W];
	logic signed [SAMPLE_W-1:0] left_s  [COUNT_W];
	logic signed [SAMPLE_W-1:0] right_s [COUNT_W];

	logic [GAIN_W-1:0] ramp_tab [DECLICK_FRAMES];

	logic             adv;
	logic             accept;
	logic             pass_in;
	gate_item_t       item_q;
	logic             item_valid_q;

	logic [PERIOD_W-1:0] phase;
	logic [PERIOD_W-1:0] k_full;
	logic [PERIOD_W:0]   ramp_end;
	logic [GAIN_W-1:0]   gain;

	assign adv      = !item_valid_q || item_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;
	assign pass_in  = bypass_in || (cfg.mix == '0);

	// declick ramp (D-k)/(D+1) in Q1.15, rounded half up
	for (genvar k = 0; k < DECLICK_FRAMES; k++) begin : g_ramp
		localparam int RampVal =
			((DECLICK_FRAMES - k) * 32768 + (DECLICK_FRAMES + 1) / 2) / (DECLICK_FRAMES + 1);
		assign ramp_tab[k] = GAIN_W'(RampVal);
	end

	for (genvar j = 0; j < COUNT_W; j++) begin : g_div
		logic [PERIOD_W:0] trial;
		logic [PERIOD_W:0] diff;

		if (j == 0) begin : g_first
			assign trial = {{PERIOD_W{1'b0}}, count_in[COUNT_W-1]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[j] <= 1'b0;
				end else if (adv) begin
					vld_s[j] <= in_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					cnt_s[j]   <= count_in;
					left_s[j]  <= left_in;
					right_s[j] <= right_in;
					pass_s[j]  <= pass_in;
				end
			end
		end else begin : g_next
			assign trial = {rem_s[j-1], cnt_s[j-1][COUNT_W-1-j]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[j] <= 1'b0;
				end else if (adv) begin
					vld_s[j] <= vld_s[j-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					cnt_s[j]   <= cnt_s[j-1];
					left_s[j]  <= left_s[j-1];
					right_s[j] <= right_s[j-1];
					pass_s[j]  <= pass_s[j-1];
				end
			end
		end

		// top bit set means trial < period: keep trial
		assign diff = trial - {1'b0, cfg.period};

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= diff[PERIOD_W] ? trial[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
			end
		end
	end

	// gate value from phase
	assign phase    = rem_s[LAST];
	assign k_full   = phase - cfg.on;
	assign ramp_end = {1'b0, cfg.on} + (PERIOD_W+1)'(DECLICK_FRAMES);

	always_comb begin
		if (cfg.period == '0 || phase < cfg.on) begin
			gain = UNITY_Q15;
		end else if (cfg.on > PERIOD_W'(DECLICK_FRAMES) && {1'b0, phase} < ramp_end) begin
			gain = ramp_tab[k_full[KW-1:0]];
		end else begin
			gain = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
		end else if (adv) begin
			item_valid_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q.left  <= left_s[LAST];
			item_q.right <= right_s[LAST];
			item_q.pass  <= pass_s[LAST];
			item_q.gain  <= gain;
		end
	end

	assign item       = item_q;
	assign item_valid = item_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/rgg_queue.sv -----
// Short FIFO between the front end and the gain stage.
`timescale 1ns / 1ps
`default_nettype none

module rgg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  rgg_pkg::gate_item_t push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output rgg_pkg::gate_item_t pop_item
);
	import rgg_pkg::*;

	gate_item_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign pop_valid  = (count_q != '0);
	// a full queue still takes a transaction when one leaves in the same cycle
	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH)) || pop_ready;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rgg_back.sv -----
// Back end: mix blend, sample scaling with rounding, output register.
`timescale 1ns / 1ps
`default_nettype none

module rgg_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [rgg_pkg::MIX_W-1:0]          mix,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  rgg_pkg::gate_item_t                in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [rgg_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [rgg_pkg::SAMPLE_W-1:0] right_out
);
	import rgg_pkg::*;

	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int RND_W  = PROD_W - 15;

	function automatic logic signed [SAMPLE_W-1:0] round_sat(
		input logic signed [PROD_W-1:0] prod
	);
		logic signed [PROD_W-1:0] biased;
		logic signed [RND_W-1:0]  r;
		begin
			biased = prod + PROD_W'(16384);
			r      = RND_W'(biased >>> 15);
			if (r > RND_W'(32767)) begin
				round_sat = 16'sh7fff;
			end else if (r < -RND_W'(32768)) begin
				round_sat = 16'sh8000;
			end else begin
				round_sat = r[SAMPLE_W-1:0];
			end
		end
	endfunction

	logic                       en;
	logic [MIX_W-1:0]           mix_sat;
	logic [2*GAIN_W-1:0]        att_sum;
	logic [GAIN_W-1:0]          scale;

	logic                       vld_s1, vld_s2, vld_s3;
	logic                       pass_s1, pass_s2;
	logic [GAIN_W-1:0]          att_s1;
	logic signed [SAMPLE_W-1:0] left_s1, right_s1, left_s2, right_s2;
	logic signed [PROD_W-1:0]   lprod_s2, rprod_s2;
	logic signed [SAMPLE_W-1:0] left_s3, right_s3;

	assign en       = !vld_s3 || out_ready;
	assign in_ready = en;
	assign mix_sat  = (mix > UNITY_Q15) ? UNITY_Q15 : mix;

	// attenuation = ((1 - g) * mix) rounded to Q1.15
	assign att_sum = (UNITY_Q15 - in_item.gain) * mix_sat + (2*GAIN_W)'(16384);
	assign scale   = UNITY_Q15 - att_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			att_s1   <= att_sum[GAIN_W+14:15];
			left_s1  <= in_item.left;
			right_s1 <= in_item.right;
			pass_s1  <= in_item.pass;

			lprod_s2 <= PROD_W'(left_s1) * $signed({1'b0, scale});
			rprod_s2 <= PROD_W'(right_s1) * $signed({1'b0, scale});
			left_s2  <= left_s1;
			right_s2 <= right_s1;
			pass_s2  <= pass_s1;

			left_s3  <= pass_s2 ? left_s2 : round_sat(lprod_s2);
			right_s3 <= pass_s2 ? right_s2 : round_sat(rprod_s2);
		end
	end

	assign out_valid = vld_s3;
	assign left_out  = left_s3;
	assign right_out = right_s3;

endmodule

`default_nettype wire

// ----- rtl/core/rhythmic_gate_gain_top.sv -----
// Top level of the rhythmic gate gain block: config registers and stream wiring.
// Throughput: one frame per cycle while the output is not stalled; set by the
//   24-stage remainder pipeline (one count bit per stage) feeding a 4-entry queue
//   and a 3-stage gain pipeline.
// Reset (arst_n low, asynchronous): config registers clear to zero, all valid flags
//   and queue pointers clear; the block accepts input right after reset.
`timescale 1ns / 1ps
`default_nettype none

module rhythmic_gate_gain_top #(
	parameter int DECLICK_FRAMES = rgg_pkg::DECLICK_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [15:0] left_in, [31:16] right_in, [55:32] frames_since_trigger
	input  logic [rgg_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
	// [0] bypass
	input  logic                                s_axis_tuser,
	// master stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] left_out, [31:16] right_out
	output logic [rgg_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
	// config write port
	input  logic                                cfg_we,
	input  logic [rgg_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [rgg_pkg::PERIOD_W-1:0]        cfg_data
);
	import rgg_pkg::*;

	cfg_t                       cfg_q;
	gate_item_t                 fr_item;
	logic                       fr_valid;
	logic                       fr_ready;
	gate_item_t                 bk_item;
	logic                       bk_valid;
	logic                       bk_ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;

	// Config writes land directly; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_PERIOD: cfg_q.period <= cfg_data;
				REG_ON:     cfg_q.on     <= cfg_data;
				REG_MIX:    cfg_q.mix    <= cfg_data[MIX_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// Front end: phase = count mod period, then gate value (open / declick ramp / closed).
	rgg_front #(
		.DECLICK_FRAMES(DECLICK_FRAMES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.left_in    (s_axis_tdata[SAMPLE_W-1:0]),
		.right_in   (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.count_in   (s_axis_tdata[TDATA_IN_W-1:2*SAMPLE_W]),
		.bypass_in  (s_axis_tuser),
		.item       (fr_item),
		.item_valid (fr_valid),
		.item_ready (fr_ready)
	);

	// Decouples the two halves so each side can stall on its own.
	rgg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_item   (bk_item)
	);

	// Back end: blend gate toward unity by mix, scale both channels, round, saturate.
	rgg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mix       (cfg_q.mix),
		.in_valid  (bk_valid),
		.in_ready  (bk_ready),
		.in_item   (bk_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.left_out  (left_out),
		.right_out (right_out)
	);

	assign m_axis_tdata = {right_out, left_out};

endmodule

`default_nettype wire

// ----- rtl/core/rgg_checker.sv -----
// Port-level checker for the rhythmic gate gain top, bound into the top level.
`timescale 1ns / 1ps
`default_nettype none

module rgg_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_axis_tvalid,
	input wire logic                               s_axis_tready,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [rgg_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

	// output transaction held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("m_axis_tvalid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("m_axis_tdata changed while stalled");

	// input side only backs up when the output side is stalled
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("s_axis_tready low without downstream stall");

	// in the cycle after reset is seen: nothing pending, input open
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid && s_axis_tready)
		else $error("block not idle after reset");

endmodule

bind rhythmic_gate_gain_top rgg_checker u_rgg_checker (.*);

`default_nettype wire
